// ===== hw/rtl/wgen_pkg.sv =====
// Package for the sine, square and trapezoid waveform generator.
// Holds sizing constants, register and mode codes, the sequencer state type
// and the quarter-wave sine table built at elaboration. No dependencies.
`default_nettype none

package wgen_pkg;

    // Sine table sizing
    localparam int SINE_QUARTER_DEPTH = 256;
    localparam int SINE_WORD_BITS     = 16;
    localparam int SINE_IDX_W         = $clog2(SINE_QUARTER_DEPTH + 1);

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes
    localparam logic [2:0] CFG_WAVE_MODE    = 3'd0;
    localparam logic [2:0] CFG_AMPLITUDE    = 3'd1;
    localparam logic [2:0] CFG_OFFSET       = 3'd2;
    localparam logic [2:0] CFG_PERIOD_TICKS = 3'd3;
    localparam logic [2:0] CFG_PHASE_TURN   = 3'd4;

    // Waveform mode codes
    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_SQUARE = 2'd1;
    localparam logic [1:0] MODE_TRAP   = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_DISPATCH,
        ST_PHASE,
        ST_LOOKUP,
        ST_SCALE,
        ST_SEG,
        ST_MUL,
        ST_RAMP,
        ST_TRAP,
        ST_FINISH
    } wgen_state_t;

    typedef logic [SINE_WORD_BITS-2:0] sine_tab_t [0:SINE_QUARTER_DEPTH];

    // Two multiplications by x, each followed by a truncating Q30 shift.
    function automatic logic [63:0] wgen_taylor_step(input logic [63:0] mag,
                                                     input logic [63:0] x);
        logic [63:0] t;
        t = (mag * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Quarter-wave table from a Taylor series of sine up to x^15, in Q30.
    function automatic sine_tab_t wgen_build_sine();
        sine_tab_t   tab;
        logic [63:0] full;
        logic [63:0] x;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] v;
        int          k;
        full = (64'd1 << (SINE_WORD_BITS - 1)) - 64'd1;
        for (k = 0; k <= SINE_QUARTER_DEPTH; k++)
        begin
            x = (HALF_PI_Q30 * 64'(k) + 64'(SINE_QUARTER_DEPTH / 2))
                / 64'(SINE_QUARTER_DEPTH);
            mag = x;
            sum = x;
            mag = wgen_taylor_step(mag, x) / 64'd6;
            sum = (sum >= mag) ? sum - mag : 64'd0;
            mag = wgen_taylor_step(mag, x) / 64'd20;
            sum = sum + mag;
            mag = wgen_taylor_step(mag, x) / 64'd42;
            sum = (sum >= mag) ? sum - mag : 64'd0;
            mag = wgen_taylor_step(mag, x) / 64'd72;
            sum = sum + mag;
            mag = wgen_taylor_step(mag, x) / 64'd110;
            sum = (sum >= mag) ? sum - mag : 64'd0;
            mag = wgen_taylor_step(mag, x) / 64'd156;
            sum = sum + mag;
            mag = wgen_taylor_step(mag, x) / 64'd210;
            sum = (sum >= mag) ? sum - mag : 64'd0;
            v = (sum * full + (64'd1 << 29)) >> 30;
            if (v > full)
            begin
                v = full;
            end
            tab[k] = v[SINE_WORD_BITS-2:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = wgen_build_sine();

endpackage

`default_nettype wire

// ===== hw/rtl/waveform_generator_sine_square_trapezoid.sv =====
// Top level of the sine, square and trapezoid test-signal generator.
// Depends on wgen_pkg for constants, the state type and the sine table.
//
// Usage: each word accepted on the request channel (req_valid high and
// req_stall low at a rising edge) carries delta_ticks, the ticks elapsed
// since the previous request, and restart. Exactly one word, sample_value,
// is returned on the response channel for each request.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data; the
// user must write it only while the block is idle, which the block itself does
// not enforce. The write takes effect at the clock edge.
// Operation: one shared restoring divider, one quotient bit per cycle under a
// small sequencer, does every division. The time is first reduced within the
// period (skipped after reset, on restart or with a zero period). A sine or
// square word then passes dispatch, the phase division (skipped with a zero
// period), lookup and scaling; a trapezoid passes dispatch, the segment
// division, the ramp product, the ramp division and segment selection. A
// trapezoid with a zero period, or another mode code, gives the offset alone.
// The finish state then loads the output register. req_stall is high while a
// request is being worked on, so none is taken before the last has left the
// sequencer. Reset clears the started flag and the time and resets the
// configuration and control registers, but not the payload registers, the
// output word among them. If the receiver stalls, the finished word waits in
// the output register and the next request may already be accepted; its
// result is held in the sequencer until the output register is free.
`default_nettype none

module waveform_generator_sine_square_trapezoid (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration port
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    // request channel
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [19:0]         delta_ticks,
    input  wire logic                restart,
    // response channel
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic signed [16:0]       sample_value
);
    import wgen_pkg::*;

    localparam int W = SINE_WORD_BITS;
    localparam logic signed [16+W:0] SCL_BIAS = (17+W)'(1) <<< (W - 2);

    // Configuration registers
    logic [1:0]         wave_mode_reg;
    logic signed [15:0] amplitude_reg;
    logic signed [15:0] offset_reg;
    logic [31:0]        period_reg;
    logic [15:0]        phase_turn_reg;

    // Sequencer and datapath state
    wgen_state_t        state_reg, state_next;
    logic               started_reg, started_next;
    logic [31:0]        time_reg, time_next;
    logic [31:0]        div_rem_reg, div_rem_next;
    logic [32:0]        div_dvd_reg, div_dvd_next;
    logic [31:0]        div_quo_reg, div_quo_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [31:0]        phase_reg, phase_next;
    logic [2:0]         seg_reg, seg_next;
    logic signed [W-1:0] sine_reg, sine_next;
    logic signed [17:0] wave_reg, wave_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic signed [16:0] sample_value_reg, sample_value_next;

    // Shared divider step
    logic [32:0]        div_shift;
    logic [32:0]        div_diff;
    logic               div_ge;
    logic [31:0]        div_rem_step;
    logic [31:0]        div_quo_step;
    logic               div_last;

    logic               req_accept;
    logic               out_free;
    logic               period_zero;
    logic [32:0]        time_sum;
    logic [34:0]        six_t;
    logic [15:0]        amp_abs;
    logic [47:0]        ramp_prod;

    // Sine lookup
    logic [31:0]            ph_total;
    logic [29+SINE_IDX_W:0] idx_prod;
    logic [SINE_IDX_W-1:0]  idx_raw;
    logic [SINE_IDX_W-1:0]  idx;
    logic [W-1:0]           tab_mag;

    // Scaling and output
    logic signed [15+W:0]   scl_prod;
    logic signed [16+W:0]   scl_sum;
    logic signed [16+W:0]   scl_shift;
    logic signed [17:0]     amp_ext;
    logic signed [17:0]     ramp;
    logic signed [18:0]     out_sum;

    assign req_accept  = req_valid && !req_stall;
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign period_zero = (period_reg == 32'd0);

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign sample_value = sample_value_reg;

    // One restoring division step: shift in the next dividend bit and
    // subtract the period where it fits.
    assign div_shift    = {div_rem_reg, div_dvd_reg[32]};
    assign div_diff     = div_shift - {1'b0, period_reg};
    assign div_ge       = (div_shift >= {1'b0, period_reg});
    assign div_rem_step = div_ge ? div_diff[31:0] : div_shift[31:0];
    assign div_quo_step = {div_quo_reg[30:0], div_ge};
    assign div_last     = (div_cnt_reg == 6'd1);

    assign time_sum  = {1'b0, time_reg} + 33'(delta_ticks);
    assign six_t     = {1'b0, time_reg, 2'b00} + {2'b00, time_reg, 1'b0};
    assign amp_abs   = amplitude_reg[15] ? 16'(-amplitude_reg) : 16'(amplitude_reg);
    assign ramp_prod = 48'(amp_abs) * 48'(div_rem_reg);

    // Quadrant from the top phase bits; index from the rest, scaled to the
    // table depth. Odd quadrants run the table backwards.
    assign ph_total = phase_reg + {phase_turn_reg, 16'h0000};
    assign idx_prod = (30 + SINE_IDX_W)'(ph_total[29:0])
                      * (30 + SINE_IDX_W)'(SINE_QUARTER_DEPTH);
    assign idx_raw  = idx_prod[29+SINE_IDX_W:30];
    assign idx      = ph_total[30] ? SINE_IDX_W'(SINE_QUARTER_DEPTH) - idx_raw : idx_raw;
    assign tab_mag  = {1'b0, SINE_TAB[idx]};

    // Sine scaling with round half up on the Q(W-1) product.
    assign scl_prod  = amplitude_reg * sine_reg;
    assign scl_sum   = {scl_prod[15+W], scl_prod} + SCL_BIAS;
    assign scl_shift = scl_sum >>> (W - 1);

    assign amp_ext = 18'(amplitude_reg);
    assign ramp    = amplitude_reg[15] ? -$signed({2'b00, div_quo_reg[15:0]})
                                       : $signed({2'b00, div_quo_reg[15:0]});

    assign out_sum = 19'(wave_reg) + 19'(offset_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (!started_reg || restart || period_zero)
                    begin
                        state_next = ST_DISPATCH;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (div_last)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (wave_mode_reg == MODE_SINE || wave_mode_reg == MODE_SQUARE)
                begin
                    state_next = period_zero ? ST_LOOKUP : ST_PHASE;
                end
                else if (wave_mode_reg == MODE_TRAP && !period_zero)
                begin
                    state_next = ST_SEG;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PHASE:
            begin
                if (div_last)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_FINISH;
            end
            ST_SEG:
            begin
                if (div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                if (div_last)
                begin
                    state_next = ST_TRAP;
                end
            end
            ST_TRAP:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        started_next      = started_reg;
        time_next         = time_reg;
        div_rem_next      = div_rem_reg;
        div_dvd_next      = div_dvd_reg;
        div_quo_next      = div_quo_reg;
        div_cnt_next      = div_cnt_reg;
        phase_next        = phase_reg;
        seg_next          = seg_reg;
        sine_next         = sine_reg;
        wave_next         = wave_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        sample_value_next = sample_value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (!started_reg || restart || period_zero)
                    begin
                        time_next    = 32'd0;
                        started_next = 1'b1;
                    end
                    else
                    begin
                        // time + delta reduced modulo the period
                        div_rem_next = 32'd0;
                        div_dvd_next = time_sum;
                        div_quo_next = 32'd0;
                        div_cnt_next = 6'd33;
                    end
                end
            end
            ST_MOD:
            begin
                div_rem_next = div_rem_step;
                div_dvd_next = {div_dvd_reg[31:0], 1'b0};
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_last)
                begin
                    time_next = div_rem_step;
                end
            end
            ST_DISPATCH:
            begin
                wave_next = 18'sd0;
                priority if (wave_mode_reg == MODE_SINE || wave_mode_reg == MODE_SQUARE)
                begin
                    // phase = time * 2^32 / period; time is below the period
                    phase_next   = 32'd0;
                    div_rem_next = time_reg;
                    div_dvd_next = 33'd0;
                    div_quo_next = 32'd0;
                    div_cnt_next = 6'd32;
                end
                else if (wave_mode_reg == MODE_TRAP && !period_zero)
                begin
                    // segment = 6 * time / period, which is below six
                    div_rem_next = six_t[34:3];
                    div_dvd_next = {six_t[2:0], 30'd0};
                    div_quo_next = 32'd0;
                    div_cnt_next = 6'd3;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg;
                end
            end
            ST_PHASE:
            begin
                div_rem_next = div_rem_step;
                div_dvd_next = {div_dvd_reg[31:0], 1'b0};
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_last)
                begin
                    phase_next = div_quo_step;
                end
            end
            ST_LOOKUP:
            begin
                sine_next = ph_total[31] ? -$signed(tab_mag) : $signed(tab_mag);
            end
            ST_SCALE:
            begin
                if (wave_mode_reg == MODE_SINE)
                begin
                    wave_next = scl_shift[17:0];
                end
                else if (sine_reg > 0)
                begin
                    wave_next = amp_ext;
                end
                else if (sine_reg < 0)
                begin
                    wave_next = -amp_ext;
                end
                else
                begin
                    wave_next = 18'sd0;
                end
            end
            ST_SEG:
            begin
                div_rem_next = div_rem_step;
                div_dvd_next = {div_dvd_reg[31:0], 1'b0};
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg - 6'd1;
                if (div_last)
                begin
                    seg_next = div_quo_step[2:0];
                end
            end
            ST_MUL:
            begin
                // |amplitude| * remainder / period; the quotient fits 16 bits
                div_rem_next = ramp_prod[47:16];
                div_dvd_next = {ramp_prod[15:0], 17'd0};
                div_quo_next = 32'd0;
                div_cnt_next = 6'd16;
            end
            ST_RAMP:
            begin
                div_rem_next = div_rem_step;
                div_dvd_next = {div_dvd_reg[31:0], 1'b0};
                div_quo_next = div_quo_step;
                div_cnt_next = div_cnt_reg - 6'd1;
            end
            ST_TRAP:
            begin
                unique case (seg_reg)
                    3'd0:    wave_next = ramp;
                    3'd1:    wave_next = amp_ext;
                    3'd2:    wave_next = amp_ext - ramp;
                    3'd3:    wave_next = -ramp;
                    3'd4:    wave_next = -amp_ext;
                    default: wave_next = ramp - amp_ext;
                endcase
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    priority if (out_sum > 19'sd65535)
                    begin
                        sample_value_next = 17'sh0FFFF;
                    end
                    else if (out_sum < -19'sd65536)
                    begin
                        sample_value_next = 17'sh10000;
                    end
                    else
                    begin
                        sample_value_next = out_sum[16:0];
                    end
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg  <= MODE_SINE;
            amplitude_reg  <= 16'sd0;
            offset_reg     <= 16'sd0;
            period_reg     <= 32'd1000000;
            phase_turn_reg <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WAVE_MODE:    wave_mode_reg  <= cfg_data[1:0];
                CFG_AMPLITUDE:    amplitude_reg  <= cfg_data[15:0];
                CFG_OFFSET:       offset_reg     <= cfg_data[15:0];
                CFG_PERIOD_TICKS: period_reg     <= cfg_data;
                CFG_PHASE_TURN:   phase_turn_reg <= cfg_data[15:0];
                default:
                begin
                    wave_mode_reg <= wave_mode_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            time_reg      <= 32'd0;
            div_cnt_reg   <= 6'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            time_reg      <= time_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        div_rem_reg      <= div_rem_next;
        div_dvd_reg      <= div_dvd_next;
        div_quo_reg      <= div_quo_next;
        phase_reg        <= phase_next;
        seg_reg          <= seg_next;
        sine_reg         <= sine_next;
        wave_reg         <= wave_next;
        sample_value_reg <= sample_value_next;
    end

endmodule

`default_nettype wire
